// ===== design/pcdr_pkg.sv =====
// ----------------------------------------------------------------------------
// pcdr_pkg
// Shared types and codes of the pointer click and drag recognizer.
// ----------------------------------------------------------------------------
package pcdr_pkg;

	localparam int COORD_BITS = 16;
	localparam int BTN_BITS   = 5;
	localparam int RADIUS_BITS = 8;
	localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 8'd3;

	localparam logic [1:0] OP_PRESS   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_MOTION  = 2'd2;
	localparam logic [1:0] OP_FRAME   = 2'd3;

	localparam logic [1:0] KIND_CLICK       = 2'd0;
	localparam logic [1:0] KIND_DRAG_START  = 2'd1;
	localparam logic [1:0] KIND_DRAG_UPDATE = 2'd2;
	localparam logic [1:0] KIND_DRAG_END    = 2'd3;

	typedef enum logic [4:0] {
		ACT_NONE        = 5'b00001,
		ACT_CLICK       = 5'b00010,
		ACT_DRAG_START  = 5'b00100,
		ACT_DRAG_UPDATE = 5'b01000,
		ACT_DRAG_END    = 5'b10000
	} act_t;

	typedef struct packed {
		logic [1:0]                   operation;
		logic [BTN_BITS-1:0]          button;
		logic [BTN_BITS-1:0]          buttons_held;
		logic signed [COORD_BITS-1:0] pos_x;
		logic signed [COORD_BITS-1:0] pos_y;
	} event_t;

	typedef struct packed {
		logic                         handled;
		logic                         action_valid;
		logic [1:0]                   action_kind;
		logic [BTN_BITS-1:0]          action_button;
		logic signed [COORD_BITS-1:0] action_x;
		logic signed [COORD_BITS-1:0] action_y;
	} result_t;

endpackage

// ===== design/pcdr_in_stage.sv =====
// ----------------------------------------------------------------------------
// pcdr_in_stage
// Input register of the event channel.
// ----------------------------------------------------------------------------
module pcdr_in_stage
	import pcdr_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   ev_valid,
	output logic   ev_stall,
	input  event_t ev,
	input  logic   s2_en,
	output logic   valid_s1,
	output event_t item_s1
);

	assign ev_stall = valid_s1 && !s2_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!ev_stall) begin
			valid_s1 <= ev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ev_valid && !ev_stall) begin
			item_s1 <= ev;
		end
	end

endmodule

// ===== design/pcdr_gesture.sv =====
// ----------------------------------------------------------------------------
// pcdr_gesture
// Gesture state and the per-event update rules.
// ----------------------------------------------------------------------------
module pcdr_gesture
	import pcdr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   adv,
	input  event_t                 item,
	input  logic [RADIUS_BITS-1:0] click_radius,
	output result_t                res
);

	logic                         tracking_q, tracking_d;
	act_t                         act_q, act_d;
	logic [BTN_BITS-1:0]          held_q, held_d;
	logic signed [COORD_BITS-1:0] start_x_q, start_x_d, start_y_q, start_y_d;
	logic signed [COORD_BITS-1:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
	logic signed [COORD_BITS:0]   dx, dy;
	logic [COORD_BITS:0]          mag_x, mag_y;
	logic                         in_range;
	logic                         handled;

	assign dx = {start_x_q[COORD_BITS-1], start_x_q} - {item.pos_x[COORD_BITS-1], item.pos_x};
	assign dy = {start_y_q[COORD_BITS-1], start_y_q} - {item.pos_y[COORD_BITS-1], item.pos_y};
	assign mag_x = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : (COORD_BITS+1)'(dx);
	assign mag_y = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : (COORD_BITS+1)'(dy);
	assign in_range = (mag_x <= (COORD_BITS+1)'(click_radius))
		&& (mag_y <= (COORD_BITS+1)'(click_radius));

	always_comb begin
		logic clear;
		clear      = 1'b0;
		handled    = 1'b0;
		tracking_d = tracking_q;
		act_d      = act_q;
		held_d     = held_q;
		start_x_d  = start_x_q;
		start_y_d  = start_y_q;
		cur_x_d    = cur_x_q;
		cur_y_d    = cur_y_q;
		case (item.operation)
			OP_PRESS: begin
				handled = 1'b1;
				if (tracking_q) begin
					clear = 1'b1;
				end else if (item.buttons_held == item.button) begin
					tracking_d = 1'b1;
					act_d      = ACT_NONE;
					held_d     = item.button;
					start_x_d  = item.pos_x;
					start_y_d  = item.pos_y;
					cur_x_d    = item.pos_x;
					cur_y_d    = item.pos_y;
				end
			end
			OP_RELEASE: begin
				if (tracking_q) begin
					handled = 1'b1;
					if (act_q == ACT_NONE) begin
						if (in_range) begin
							act_d = ACT_CLICK;
						end else begin
							clear = 1'b1;
						end
					end else if (act_q == ACT_DRAG_START || act_q == ACT_DRAG_UPDATE) begin
						cur_x_d = item.pos_x;
						cur_y_d = item.pos_y;
						act_d   = ACT_DRAG_END;
					end
				end
			end
			OP_MOTION: begin
				if (tracking_q) begin
					if (act_q == ACT_NONE) begin
						if (!in_range) begin
							act_d   = ACT_DRAG_START;
							handled = 1'b1;
						end
					end else if (act_q == ACT_DRAG_START || act_q == ACT_DRAG_UPDATE) begin
						act_d   = ACT_DRAG_UPDATE;
						cur_x_d = item.pos_x;
						cur_y_d = item.pos_y;
						handled = 1'b1;
					end
				end
			end
			default: begin
				if (act_q == ACT_CLICK || act_q == ACT_DRAG_END) begin
					clear = 1'b1;
				end
			end
		endcase
		if (clear) begin
			tracking_d = 1'b0;
			act_d      = ACT_NONE;
			held_d     = '0;
			start_x_d  = '0;
			start_y_d  = '0;
			cur_x_d    = '0;
			cur_y_d    = '0;
		end
	end

	always_comb begin
		res               = '0;
		res.handled       = handled;
		res.action_valid  = 1'b1;
		res.action_button = held_d;
		res.action_x      = cur_x_d;
		res.action_y      = cur_y_d;
		case (act_d)
			ACT_CLICK:       res.action_kind = KIND_CLICK;
			ACT_DRAG_START:  res.action_kind = KIND_DRAG_START;
			ACT_DRAG_UPDATE: res.action_kind = KIND_DRAG_UPDATE;
			ACT_DRAG_END:    res.action_kind = KIND_DRAG_END;
			default: begin
				res.action_valid  = 1'b0;
				res.action_button = '0;
				res.action_x      = '0;
				res.action_y      = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tracking_q <= 1'b0;
			act_q      <= ACT_NONE;
			held_q     <= '0;
			start_x_q  <= '0;
			start_y_q  <= '0;
			cur_x_q    <= '0;
			cur_y_q    <= '0;
		end else if (adv) begin
			tracking_q <= tracking_d;
			act_q      <= act_d;
			held_q     <= held_d;
			start_x_q  <= start_x_d;
			start_y_q  <= start_y_d;
			cur_x_q    <= cur_x_d;
			cur_y_q    <= cur_y_d;
		end
	end

endmodule

// ===== design/pcdr_out_stage.sv =====
// ----------------------------------------------------------------------------
// pcdr_out_stage
// Result register of the result channel.
// ----------------------------------------------------------------------------
module pcdr_out_stage
	import pcdr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    valid_s1,
	input  result_t res_d,
	output logic    s2_en,
	output logic    res_valid,
	input  logic    res_stall,
	output result_t res
);

	assign s2_en = !res_valid || !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (s2_en) begin
			res_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_en && valid_s1) begin
			res <= res_d;
		end
	end

endmodule

// ===== design/pointer_click_drag_recognizer.sv =====
// ----------------------------------------------------------------------------
// pointer_click_drag_recognizer
// Click and drag gesture recognizer for pointer events.
// ----------------------------------------------------------------------------
// Takes pointer event words (press, release, motion, frame start) and
// returns one result word for each, in order. An event is registered in the
// input register, passed through the gesture update logic and the result
// lands in the output register, so a new event can be taken every cycle
// while the result side keeps up; when the result word is held, ev_stall
// rises as soon as the input register is also full, so at most one further
// event is taken. click_radius is written through the cfg channel, which is
// always ready, and should only change while no event is in flight.
module pointer_click_drag_recognizer
	import pcdr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   ev_valid,
	output logic                   ev_stall,
	input  event_t                 ev,
	output logic                   res_valid,
	input  logic                   res_stall,
	output result_t                res,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [RADIUS_BITS-1:0] cfg_data
);

	logic                   valid_s1;
	event_t                 item_s1;
	logic                   s2_en;
	result_t                res_d;
	logic [RADIUS_BITS-1:0] radius_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			radius_q <= cfg_data;
		end
	end

	pcdr_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_valid (ev_valid),
		.ev_stall (ev_stall),
		.ev       (ev),
		.s2_en    (s2_en),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	pcdr_gesture u_gesture (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (valid_s1 && s2_en),
		.item         (item_s1),
		.click_radius (radius_q),
		.res          (res_d)
	);

	pcdr_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res_d     (res_d),
		.s2_en     (s2_en),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

endmodule

// ===== design/pcdr_checker.sv =====
// ----------------------------------------------------------------------------
// pcdr_checker
// Port-level checks of the recognizer, bound to the top level.
// ----------------------------------------------------------------------------
module pcdr_checker
	import pcdr_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    ev_valid,
	input logic    ev_stall,
	input logic    res_valid,
	input logic    res_stall,
	input result_t res
);

	// input side only backs up behind a held result word
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		ev_stall |-> (res_valid && res_stall))
		else $error("event stall without held result");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(res)))
		else $error("held result word changed");

	a_no_action_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res.action_valid) |-> (res.action_kind == 2'd0
			&& res.action_button == '0 && res.action_x == '0 && res.action_y == '0))
		else $error("action fields not cleared without action");

	// a new result word follows an accepted event through the input and output registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(ev_valid && !ev_stall, 2))
		else $error("result without accepted event");

endmodule

bind pointer_click_drag_recognizer pcdr_checker u_pcdr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.ev_valid  (ev_valid),
	.ev_stall  (ev_stall),
	.res_valid (res_valid),
	.res_stall (res_stall),
	.res       (res)
);

// ===== test/pointer_click_drag_recognizer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pointer_click_drag_recognizer_test
// Self-checking bench for the click and drag gesture recognizer.
// ----------------------------------------------------------------------------
// A queue of pointer event words feeds a clocked driver with random gaps; a
// clocked monitor stalls the result side at random and compares every result
// word against a gesture tracker kept in the bench. A short directed sequence
// runs at the reset click radius, then random gestures and noise run under
// several radius settings, the extremes among them.
module pointer_click_drag_recognizer_test;
	import pcdr_pkg::*;

	localparam int STUCK_LIMIT = 3000;

	logic                   clk;
	logic                   arst_n;
	logic                   ev_valid;
	logic                   ev_stall;
	event_t                 ev;
	logic                   res_valid;
	logic                   res_stall;
	result_t                res;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [RADIUS_BITS-1:0] cfg_data;

	pointer_click_drag_recognizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.ev_valid  (ev_valid),
		.ev_stall  (ev_stall),
		.ev        (ev),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	event_t  event_queue[$];
	result_t predicted_results[$];
	int      queued;
	int      mismatches;
	int      stuck_cycles;
	int      ev_gap;
	int      res_hold;
	bit      ev_calm;
	bit      res_calm;

	// gesture tracker
	logic                         gest_tracking;
	act_t                         gest_action;
	logic [BTN_BITS-1:0]          gest_button;
	logic signed [COORD_BITS-1:0] gest_start_x;
	logic signed [COORD_BITS-1:0] gest_start_y;
	logic signed [COORD_BITS-1:0] gest_cur_x;
	logic signed [COORD_BITS-1:0] gest_cur_y;
	logic [RADIUS_BITS-1:0]       radius_copy;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void drop_gesture();
		gest_tracking = 1'b0;
		gest_action   = ACT_NONE;
		gest_button   = '0;
		gest_start_x  = '0;
		gest_start_y  = '0;
		gest_cur_x    = '0;
		gest_cur_y    = '0;
	endfunction

	function automatic bit within_radius(logic signed [COORD_BITS-1:0] x,
			logic signed [COORD_BITS-1:0] y);
		int dx;
		int dy;
		int rad;
		dx = gest_start_x - x;
		dy = gest_start_y - y;
		rad = radius_copy;
		if (dx < 0) dx = -dx;
		if (dy < 0) dy = -dy;
		return dx <= rad && dy <= rad;
	endfunction

	function automatic result_t predict_gesture(event_t e);
		result_t r;
		logic    handled;
		handled = 1'b0;
		case (e.operation)
			OP_PRESS: begin
				handled = 1'b1;
				if (gest_tracking) begin
					drop_gesture();
				end else if (e.buttons_held == e.button) begin
					gest_tracking = 1'b1;
					gest_action   = ACT_NONE;
					gest_button   = e.button;
					gest_start_x  = e.pos_x;
					gest_start_y  = e.pos_y;
					gest_cur_x    = e.pos_x;
					gest_cur_y    = e.pos_y;
				end
			end
			OP_RELEASE: begin
				if (gest_tracking) begin
					handled = 1'b1;
					if (gest_action == ACT_NONE) begin
						if (within_radius(e.pos_x, e.pos_y))
							gest_action = ACT_CLICK;
						else
							drop_gesture();
					end else if (gest_action == ACT_DRAG_START ||
							gest_action == ACT_DRAG_UPDATE) begin
						gest_cur_x  = e.pos_x;
						gest_cur_y  = e.pos_y;
						gest_action = ACT_DRAG_END;
					end
				end
			end
			OP_MOTION: begin
				if (gest_tracking) begin
					if (gest_action == ACT_NONE) begin
						if (!within_radius(e.pos_x, e.pos_y)) begin
							gest_action = ACT_DRAG_START;
							handled = 1'b1;
						end
					end else if (gest_action == ACT_DRAG_START ||
							gest_action == ACT_DRAG_UPDATE) begin
						gest_action = ACT_DRAG_UPDATE;
						gest_cur_x  = e.pos_x;
						gest_cur_y  = e.pos_y;
						handled = 1'b1;
					end
				end
			end
			default: begin
				if (gest_action == ACT_CLICK || gest_action == ACT_DRAG_END)
					drop_gesture();
			end
		endcase
		r = '0;
		r.handled = handled;
		if (gest_action != ACT_NONE) begin
			r.action_valid  = 1'b1;
			r.action_button = gest_button;
			r.action_x      = gest_cur_x;
			r.action_y      = gest_cur_y;
			case (gest_action)
				ACT_CLICK:       r.action_kind = KIND_CLICK;
				ACT_DRAG_START:  r.action_kind = KIND_DRAG_START;
				ACT_DRAG_UPDATE: r.action_kind = KIND_DRAG_UPDATE;
				default:         r.action_kind = KIND_DRAG_END;
			endcase
		end
		return r;
	endfunction

	task automatic check_result(input result_t got);
		result_t want;
		if (predicted_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result word with nothing pending: %h", $time, got);
		end else begin
			want = predicted_results.pop_front();
			if (got.handled !== want.handled || got.action_valid !== want.action_valid ||
					got.action_kind !== want.action_kind ||
					got.action_button !== want.action_button ||
					got.action_x !== want.action_x || got.action_y !== want.action_y) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: mismatch, expected h=%b v=%b k=%0d b=%b x=%0d y=%0d",
						$time, want.handled, want.action_valid, want.action_kind,
						want.action_button, want.action_x, want.action_y);
					$display("%0t:           got      h=%b v=%b k=%0d b=%b x=%0d y=%0d",
						$time, got.handled, got.action_valid, got.action_kind,
						got.action_button, got.action_x, got.action_y);
				end
			end
		end
	endtask

	function automatic int idle_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// event driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (ev_valid && !ev_stall)
				predicted_results.push_back(predict_gesture(ev));
			if (!ev_valid || !ev_stall) begin
				if (ev_gap > 0) begin
					ev_gap--;
					ev_valid <= 1'b0;
				end else if (event_queue.size() > 0) begin
					ev <= event_queue.pop_front();
					ev_valid <= 1'b1;
					if ($urandom_range(0, 79) == 0) ev_calm = !ev_calm;
					ev_gap = ev_calm ? 0 : idle_len();
				end else begin
					ev_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall)
				check_result(res);
			if (res_hold > 0) begin
				res_hold--;
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
				if ($urandom_range(0, 79) == 0) res_calm = !res_calm;
				if (!res_calm && $urandom_range(0, 3) == 0) res_hold = idle_len();
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((ev_valid && !ev_stall) || (res_valid && !res_stall) ||
					(cfg_valid && cfg_ready))
				stuck_cycles = 0;
			else
				stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, STUCK_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	task automatic queue_event(input logic [1:0] op, input logic [BTN_BITS-1:0] btn,
			input logic [BTN_BITS-1:0] held, input logic signed [COORD_BITS-1:0] x,
			input logic signed [COORD_BITS-1:0] y);
		event_t e;
		e.operation    = op;
		e.button       = btn;
		e.buttons_held = held;
		e.pos_x        = x;
		e.pos_y        = y;
		event_queue.push_back(e);
		queued++;
	endtask

	function automatic logic signed [COORD_BITS-1:0] rand_coord();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0) begin
			case ($urandom_range(0, 3))
				0: return 16'sh7fff;
				1: return 16'sh8000;
				2: return 16'sh0000;
				default: return 16'shffff;
			endcase
		end
		if (roll < 4) return COORD_BITS'(int'($urandom_range(0, 200)) - 100);
		return COORD_BITS'($urandom);
	endfunction

	function automatic logic signed [COORD_BITS-1:0] shift_coord(
			logic signed [COORD_BITS-1:0] c, bit close);
		int rad;
		int off;
		int roll;
		rad = radius_copy;
		roll = close ? 0 : $urandom_range(0, 9);
		if (roll < 4) off = $urandom_range(0, rad);
		else if (roll == 4) off = rad;
		else if (roll == 5) off = rad + 1;
		else if (roll < 8) off = $urandom_range(rad + 1, rad + 50);
		else off = $urandom_range(0, 65535);
		if ($urandom_range(0, 1)) off = -off;
		return COORD_BITS'(c + off);
	endfunction

	task automatic add_gesture();
		logic [BTN_BITS-1:0]          b;
		logic signed [COORD_BITS-1:0] sx;
		logic signed [COORD_BITS-1:0] sy;
		int                           roll;
		b = BTN_BITS'(1) << $urandom_range(0, BTN_BITS - 1);
		if ($urandom_range(0, 15) == 0) b = '0;
		sx = rand_coord();
		sy = rand_coord();
		queue_event(OP_PRESS, b, b, sx, sy);
		repeat ($urandom_range(0, 4))
			queue_event(OP_MOTION, BTN_BITS'($urandom), b, shift_coord(sx, 1'b0),
				shift_coord(sy, 1'b0));
		roll = $urandom_range(0, 9);
		if (roll < 7) begin
			queue_event(OP_RELEASE, ($urandom_range(0, 4) == 0) ? BTN_BITS'($urandom) : b,
				BTN_BITS'($urandom), shift_coord(sx, roll < 4), shift_coord(sy, roll < 4));
			if ($urandom_range(0, 4) == 0)
				queue_event(OP_RELEASE, b, '0, rand_coord(), rand_coord());
		end else if (roll < 9) begin
			queue_event(OP_PRESS, BTN_BITS'($urandom), BTN_BITS'($urandom), rand_coord(),
				rand_coord());
		end
		if ($urandom_range(0, 3) != 0)
			queue_event(OP_FRAME, BTN_BITS'($urandom), BTN_BITS'($urandom), rand_coord(),
				rand_coord());
	endtask

	task automatic add_random_phase(input int count);
		logic [BTN_BITS-1:0] b;
		queued = 0;
		while (queued < count) begin
			if ($urandom_range(0, 3) != 0) begin
				add_gesture();
			end else begin
				b = BTN_BITS'($urandom);
				queue_event(2'($urandom), b, ($urandom_range(0, 2) == 0) ? b : BTN_BITS'($urandom),
					rand_coord(), rand_coord());
			end
		end
	endtask

	// sampled away from the driving edge so a word just popped shows on ev_valid
	task automatic wait_drained();
		while (event_queue.size() > 0 || ev_valid || predicted_results.size() > 0)
			@(negedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_radius(input logic [RADIUS_BITS-1:0] r);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= r;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		radius_copy = r;
	endtask

	initial begin
		logic [RADIUS_BITS-1:0] radii[7];
		arst_n    = 1'b0;
		ev_valid  = 1'b0;
		ev        = '0;
		res_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		ev_gap    = 0;
		res_hold  = 0;
		ev_calm   = 1'b0;
		res_calm  = 1'b0;
		mismatches   = 0;
		stuck_cycles = 0;
		radius_copy  = RADIUS_RESET;
		drop_gesture();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed sequence at the reset radius
		queue_event(OP_RELEASE, 5'b00001, 5'b00001, 10, 10);
		queue_event(OP_MOTION, 5'b00000, 5'b00000, 500, 500);
		queue_event(OP_FRAME, 5'b00000, 5'b00000, 0, 0);
		queue_event(OP_PRESS, 5'b00000, 5'b00000, 20, -20);
		queue_event(OP_MOTION, 5'b00000, 5'b00000, 23, -23);
		queue_event(OP_RELEASE, 5'b00000, 5'b00000, 17, -17);
		queue_event(OP_RELEASE, 5'b00000, 5'b00000, 900, 900);
		queue_event(OP_MOTION, 5'b00000, 5'b00000, 900, 900);
		queue_event(OP_FRAME, 5'b11111, 5'b11111, -1, -1);
		queue_event(OP_PRESS, 5'b00010, 5'b00110, 0, 0);
		queue_event(OP_PRESS, 5'b10000, 5'b10000, 16'sh7fff, 16'sh8000);
		queue_event(OP_MOTION, 5'b10000, 5'b10000, 16'sh7ffb, 16'sh8000);
		queue_event(OP_FRAME, 5'b00000, 5'b00000, 0, 0);
		queue_event(OP_MOTION, 5'b10000, 5'b10000, 16'sh8000, 16'sh7fff);
		queue_event(OP_PRESS, 5'b00001, 5'b10001, 0, 0);
		queue_event(OP_PRESS, 5'b00100, 5'b00100, 0, 0);
		queue_event(OP_RELEASE, 5'b00100, 5'b00000, 4, 0);
		queue_event(OP_PRESS, 5'b01000, 5'b01000, 100, 100);
		queue_event(OP_MOTION, 5'b00000, 5'b01000, 100, 104);
		queue_event(OP_RELEASE, 5'b00001, 5'b01000, 50, 50);
		queue_event(OP_RELEASE, 5'b01000, 5'b00000, 60, 60);
		queue_event(OP_MOTION, 5'b00000, 5'b00000, 70, 70);
		queue_event(OP_FRAME, 5'b00000, 5'b00000, 0, 0);
		queue_event(OP_PRESS, 5'b00010, 5'b00010, -5, -5);
		queue_event(OP_RELEASE, 5'b00010, 5'b00000, -2, -8);
		queue_event(OP_FRAME, 5'b00000, 5'b00000, 0, 0);
		wait_drained();

		radii = '{8'd0, 8'd255, 8'd1, RADIUS_BITS'($urandom_range(2, 254)), 8'd3, 8'd17,
			RADIUS_BITS'($urandom)};
		foreach (radii[i]) begin
			write_radius(radii[i]);
			add_random_phase(205);
			wait_drained();
		end

		repeat (8) @(posedge clk);
		if (mismatches == 0 && predicted_results.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
